/* sv/lspt_pkg.sv */
package lspt_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int ELEM_W       = 16;
  localparam int SUM_W        = 32;
  localparam int OUT_LEN_W    = 11;

  // one element's search packet as it walks the cell chain
  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic                 ign;   // element beyond capacity
    logic                 ovf;
    logic [SUM_W-1:0]     pfx;   // prefix sum after this element
    logic [SUM_W:0]       rem;   // prefix minus target, exact
    logic [IDX_W-1:0]     idx;   // element position
    logic [CNT_W-1:0]     best;
    logic                 fnd;
    logic                 have;  // prefix already in table or inserted
  } pkt_t;

endpackage

/* sv/lspt_channels.sv */
interface lspt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lspt_pkg::ELEM_W-1:0]  element_value;
  logic                                last;

  modport source (output valid, output element_value, output last, input ready);
  modport sink   (input valid, input element_value, input last, output ready);
endinterface

interface lspt_out_if;
  logic                                valid;
  logic                                ready;
  logic [lspt_pkg::OUT_LEN_W-1:0]      best_length;
  logic                                found;
  logic                                overflow;

  modport source (output valid, output best_length, output found, output overflow,
                  input ready);
  modport sink   (input valid, input best_length, input found, input overflow,
                  output ready);
endinterface

/* sv/lspt_cell.sv */
module lspt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  lspt_pkg::pkt_t pkt_i,
  output lspt_pkg::pkt_t pkt_o
);
  import lspt_pkg::*;

  logic             ent_vld_r, ent_vld_nxt;
  logic [SUM_W-1:0] ent_sum_r, ent_sum_nxt;
  logic [IDX_W-1:0] ent_pos_r, ent_pos_nxt;
  pkt_t             pkt_r, pkt_nxt;
  logic [CNT_W-1:0] cand;

  always_comb begin
    ent_vld_nxt = ent_vld_r;
    ent_sum_nxt = ent_sum_r;
    ent_pos_nxt = ent_pos_r;
    pkt_nxt     = pkt_i;
    cand        = CNT_W'(pkt_i.idx) - CNT_W'(ent_pos_r);
    if (pkt_i.vld && !pkt_i.ign) begin
      if (ent_vld_r) begin
        if ({ent_sum_r[SUM_W-1], ent_sum_r} == pkt_i.rem) begin
          pkt_nxt.fnd = 1'b1;
          if (cand > pkt_i.best) begin
            pkt_nxt.best = cand;
          end
        end
        if (ent_sum_r == pkt_i.pfx) begin
          pkt_nxt.have = 1'b1;
        end
      end else if (!pkt_i.have) begin
        // first free cell: all stored sums were already seen
        ent_vld_nxt  = 1'b1;
        ent_sum_nxt  = pkt_i.pfx;
        ent_pos_nxt  = pkt_i.idx;
        pkt_nxt.have = 1'b1;
      end
    end
    // end of array wipes the cell behind the packet
    if (pkt_i.vld && pkt_i.last) begin
      ent_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      pkt_r     <= '0;
    end else if (en) begin
      ent_vld_r <= ent_vld_nxt;
      pkt_r     <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_sum_r <= ent_sum_nxt;
      ent_pos_r <= ent_pos_nxt;
    end
  end

  assign pkt_o = pkt_r;

endmodule

/* sv/longest_subarray_sum_prefix_table.sv */
// longest subarray with a given sum: elements stream in one per transfer, the
// last one marked; a result transfer follows each marked element with the
// longest run summing to target_sum, a found flag and an overflow flag.
// one element is taken every cycle while the result side keeps up; a result
// is registered after the last packet walks the entry stage and the chain of
// MAX_ELEMENTS table cells (one entry stage, one register per cell). a stalled
// result holds the whole chain and the input side. target_sum must be written
// only while no array is in flight, by the user; the block does not enforce it.
module longest_subarray_sum_prefix_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lspt_pkg::SUM_W-1:0] cfg_wdata,
  lspt_in_if.sink                    in_ch,
  lspt_out_if.source                 out_ch
);
  import lspt_pkg::*;

  // configuration
  logic [SUM_W-1:0] target_r;

  // entry side running state
  logic [SUM_W-1:0] run_sum_r, run_sum_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  pkt_t             ent_pkt_r, ent_pkt_nxt;

  // exit side accumulation and result register
  logic [CNT_W-1:0]     acc_best_r, acc_best_nxt;
  logic                 acc_fnd_r, acc_fnd_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_LEN_W-1:0] out_best_r;
  logic                 out_fnd_r;
  logic                 out_ovf_r;
  logic [CNT_W-1:0]     mrg_best;
  logic                 mrg_fnd;

  logic             en;
  logic             in_xfer;
  logic [SUM_W-1:0] ext;
  logic [SUM_W-1:0] sum_add;
  pkt_t             x_pkt;

  // packets between cells, cell k reads chain[k] and drives chain[k+1]
  pkt_t chain [0:MAX_ELEMENTS];

  // the chain moves only when the result slot can take what leaves it
  assign en        = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_xfer   = in_ch.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_we) begin
      target_r <= cfg_wdata;
    end
  end

  // entry stage: prefix sum, exact difference to target, start-at-zero match, overflow flag
  always_comb begin
    ext         = {{(SUM_W-ELEM_W){in_ch.element_value[ELEM_W-1]}}, in_ch.element_value};
    sum_add     = run_sum_r + ext;
    run_sum_nxt = run_sum_r;
    pos_nxt     = pos_r;
    ovf_nxt     = ovf_r;
    ent_pkt_nxt = '0;
    if (in_xfer) begin
      ent_pkt_nxt.vld  = 1'b1;
      ent_pkt_nxt.last = in_ch.last;
      ent_pkt_nxt.pfx  = sum_add;
      ent_pkt_nxt.rem  = {sum_add[SUM_W-1], sum_add} - {target_r[SUM_W-1], target_r};
      ent_pkt_nxt.idx  = pos_r[IDX_W-1:0];
      if (pos_r < CNT_W'(MAX_ELEMENTS)) begin
        run_sum_nxt = sum_add;
        pos_nxt     = pos_r + 1'b1;
        if (sum_add == target_r) begin
          ent_pkt_nxt.fnd  = 1'b1;
          ent_pkt_nxt.best = pos_r + 1'b1;
        end
      end else begin
        // table full: element only raises the flag
        ent_pkt_nxt.ign = 1'b1;
        ovf_nxt         = 1'b1;
      end
      ent_pkt_nxt.ovf = ovf_nxt;
      if (in_ch.last) begin
        run_sum_nxt = '0;
        pos_nxt     = '0;
        ovf_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sum_r <= '0;
      pos_r     <= '0;
      ovf_r     <= 1'b0;
      ent_pkt_r <= '0;
    end else if (en) begin
      run_sum_r <= run_sum_nxt;
      pos_r     <= pos_nxt;
      ovf_r     <= ovf_nxt;
      ent_pkt_r <= ent_pkt_nxt;
    end
  end

  // table cell chain
  assign chain[0] = ent_pkt_r;

  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    lspt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .pkt_i (chain[k]),
      .pkt_o (chain[k+1])
    );
  end

  assign x_pkt = chain[MAX_ELEMENTS];

  // exit: fold each packet's best into the array total, emit on the last one
  always_comb begin
    mrg_best = acc_best_r;
    mrg_fnd  = acc_fnd_r;
    if (x_pkt.vld && !x_pkt.ign) begin
      mrg_fnd = acc_fnd_r | x_pkt.fnd;
      if (x_pkt.best > acc_best_r) begin
        mrg_best = x_pkt.best;
      end
    end
    acc_best_nxt  = acc_best_r;
    acc_fnd_nxt   = acc_fnd_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (en && x_pkt.vld) begin
      if (x_pkt.last) begin
        acc_best_nxt  = '0;
        acc_fnd_nxt   = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        acc_best_nxt = mrg_best;
        acc_fnd_nxt  = mrg_fnd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_best_r  <= '0;
      acc_fnd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_best_r  <= acc_best_nxt;
      acc_fnd_r   <= acc_fnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded with the array-ending packet
  always_ff @(posedge clk) begin
    if (en && x_pkt.vld && x_pkt.last) begin
      out_best_r <= OUT_LEN_W'(mrg_best);
      out_fnd_r  <= mrg_fnd;
      out_ovf_r  <= x_pkt.ovf;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.best_length = out_best_r;
  assign out_ch.found       = out_fnd_r;
  assign out_ch.overflow    = out_ovf_r;

endmodule

/* dv/tb_longest_subarray_sum_prefix_table.sv */
module tb_longest_subarray_sum_prefix_table;
  timeunit 1ns;
  timeprecision 1ps;

  import lspt_pkg::*;

  // registers between an element and its result: entry stage, table cells, result register
  localparam int PIPE_LATENCY  = MAX_ELEMENTS + 2;
  // quiet time before a register write or the final verdict
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 16;
  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT   = 4 * PIPE_LATENCY + 4000;
  localparam int IDLE_PERCENT  = 33;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 110;

  // one array element as queued for the input side
  typedef struct {
    logic signed [ELEM_W-1:0] value;
    logic                     last;
  } element_t;

  // one end-of-array report
  typedef struct packed {
    logic [OUT_LEN_W-1:0] best_length;
    logic                 found;
    logic                 overflow;
  } array_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [SUM_W-1:0] cfg_wdata;

  lspt_in_if  in_ch ();
  lspt_out_if out_ch ();

  longest_subarray_sum_prefix_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // prefix-sum tracker: mirrors the block's running state
  // ---------------------------------------------------------------------------
  int            target_shadow;      // current target_sum as written
  int            run_sum;            // 32-bit prefix, wraps like the block
  int unsigned   elem_count;         // elements taken into this array
  int unsigned   longest_run;
  bit            any_match;
  bit            overflowed;
  int unsigned   first_pos [int];    // prefix sum -> first position seen

  array_result_t awaited_results [$];
  element_t      queued_elements [$];

  // run statistics for the closing summary
  int unsigned   arrays_queued;
  int unsigned   elements_taken;
  int unsigned   elements_dropped;
  int unsigned   targets_written;
  int unsigned   results_checked;
  int unsigned   arrays_matched;
  int unsigned   mismatches;

  function automatic void note_run(int unsigned len);
    any_match = 1'b1;
    if (len > longest_run) longest_run = len;
  endfunction

  // fold one accepted element into the tracker, queue a report on the last one
  function automatic void absorb_element(logic signed [ELEM_W-1:0] value, logic last);
    longint remain;
    elements_taken++;
    if (elem_count < MAX_ELEMENTS) begin
      run_sum = run_sum + int'(value);
      // exact difference, no wrap can fake a hit
      remain = longint'(run_sum) - longint'(target_shadow);
      // run starting at position zero
      if (run_sum == target_shadow) note_run(elem_count + 1);
      // run starting just after the first position of prefix - target
      if (remain == longint'(int'(remain)) && first_pos.exists(int'(remain)))
        note_run(elem_count - first_pos[int'(remain)]);
      if (!first_pos.exists(run_sum)) first_pos[run_sum] = elem_count;
      elem_count++;
    end else begin
      // table full: element dropped, only the flag remembers it
      overflowed = 1'b1;
      elements_dropped++;
    end
    if (last) begin
      awaited_results.push_back('{best_length: OUT_LEN_W'(longest_run),
                                  found: any_match, overflow: overflowed});
      run_sum     = 0;
      elem_count  = 0;
      longest_run = 0;
      any_match   = 1'b0;
      overflowed  = 1'b0;
      first_pos.delete();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  bit       steady;     // no idling on either side while set
  bit       in_taken;   // current element moved at the last rising edge
  element_t next_elem;

  // accept bookkeeping at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      absorb_element(in_ch.element_value, in_ch.last);
      in_taken = 1'b1;
    end
  end

  // driver: offers a new element at the falling edge once the old one moved
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (queued_elements.size() != 0 &&
          (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        next_elem = queued_elements.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.element_value <= next_elem.value;
        in_ch.last          <= next_elem.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  array_result_t want;

  // random backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // monitor: every result transfer is held against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: best_length %0d found %0b overflow %0b",
                   out_ch.best_length, out_ch.found, out_ch.overflow);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (want.found) arrays_matched++;
        if (out_ch.best_length !== want.best_length || out_ch.found !== want.found ||
            out_ch.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d mismatch (exp/got): len %0d/%0d found %0b/%0b ovf %0b/%0b",
                     results_checked, want.best_length, out_ch.best_length,
                     want.found, out_ch.found, want.overflow, out_ch.overflow);
        end
      end
    end
  end

  // watchdog on transfers of either channel
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_array(input int vals [$]);
    element_t e;
    foreach (vals[k]) begin
      e.value = ELEM_W'(vals[k]);
      e.last  = (k == vals.size() - 1);
      queued_elements.push_back(e);
    end
    arrays_queued++;
  endfunction

  // sender holds off until everything sent has come back, then lets the chain drain
  task automatic settle_block();
    do @(posedge clk); while (queued_elements.size() != 0 || in_ch.valid);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_target(int value);
    @(negedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= value;
    target_shadow  = value;
    targets_written++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int vals [$];
    int phase_target [RANDOM_PHASES];
    int phase_items;
    int len;
    int style;
    int v;
    int total;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.element_value = '0;
    in_ch.last          = 1'b0;
    out_ch.ready        = 1'b0;
    steady              = 1'b0;
    target_shadow       = 0;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed, target at its reset value of zero
    vals = '{0};                               // single zero element
    queue_array(vals);
    vals = '{32767, -32768, 1};                // extremes, whole array sums to zero
    queue_array(vals);
    vals = '{7};                               // no match at all
    queue_array(vals);
    vals = '{-32768, -32768, 32767, 32767, 2}; // deep negative prefix back to zero
    queue_array(vals);
    settle_block();

    // directed, positive target with matches at and away from position zero
    write_target(5);
    vals = '{2, 3, -1, 1, 5};
    queue_array(vals);
    vals = '{-5, 10};
    queue_array(vals);
    settle_block();

    // directed, negative target
    write_target(-1);
    vals = '{1, -1, -1, 0};
    queue_array(vals);
    settle_block();

    // random phases, extremes of the register among them
    phase_target[0] = 32'sh8000_0000;
    phase_target[1] = 32'sh7FFF_FFFF;
    phase_target[2] = 0;
    phase_target[3] = 3;
    phase_target[4] = -7;
    phase_target[5] = int'($urandom_range(0, 40)) - 20;
    phase_target[6] = int'($urandom);
    phase_target[7] = 1;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_target(phase_target[p]);
      // one phase runs with both sides at full rate
      steady = (p == 3);

      if (p == 2) begin
        // capacity case: first MAX_ELEMENTS elements sum to zero, one more dropped
        vals  = {};
        total = 0;
        for (int k = 0; k < MAX_ELEMENTS - 1; k++) begin
          v = int'($urandom_range(0, 2)) - 1;
          total += v;
          vals.push_back(v);
        end
        vals.push_back(-total);
        vals.push_back(int'($urandom_range(0, 9)) - 5);
        queue_array(vals);
      end

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        vals  = {};
        len   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 90);
        style = $urandom_range(0, 99);
        for (int k = 0; k < len; k++) begin
          if (style < 55) begin
            // small values, prefixes revisit often
            v = int'($urandom_range(0, 8)) - 4;
          end else if (style < 75) begin
            // full-range noise
            v = int'(shortint'($urandom));
          end else if (style < 88) begin
            case ($urandom_range(0, 3))
              0:       v = -32768;
              1:       v = 32767;
              2:       v = 0;
              default: v = -1;
            endcase
          end else if ($urandom_range(0, 3) == 0 && target_shadow >= -32768 &&
                       target_shadow <= 32767) begin
            // the target itself as a one-element run
            v = target_shadow;
          end else begin
            v = int'($urandom_range(0, 6)) - 3;
          end
          vals.push_back(v);
        end
        queue_array(vals);
        phase_items += len;
      end
      settle_block();
    end
    steady = 1'b0;

    $display("covered %0d arrays, %0d elements (%0d beyond table capacity), %0d target writes",
             arrays_queued, elements_taken, elements_dropped, targets_written);
    $display("checked %0d reports, %0d with a matching run", results_checked, arrays_matched);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
